>>> design/assert_macros.svh
// Assertion macros used by the RTL of the pair distance histogram.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication whose consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/pdh_pkg.sv
// Package for the pair distance histogram: constants, codes and state type.
// Depends on nothing.
`default_nettype none
package pdh_pkg;
    localparam int MAX_POINTS_DEF  = 64;
    localparam int BUCKETS_DEF     = 16;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int CNT_W           = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [23:0] WIDTH_RESET = 24'd256;

    localparam logic [1:0] MODE_REF    = 2'd0;
    localparam logic [1:0] MODE_NBR    = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_AREA  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_DIFF,
        ST_SQ,
        ST_SUM,
        ST_BIN,
        ST_ADV,
        ST_NSETUP,
        ST_NMUL,
        ST_DMUL,
        ST_DIV,
        ST_OUT,
        ST_CLR
    } state_t;
endpackage
`default_nettype wire

>>> design/pair_distance_histogram.sv
// Pair distance histogram top level: point stores, shared multiply unit,
// bit-serial divider and the sequencer. Depends on pdh_pkg, assert_macros.svh.
// Usage: modes 0 and 1 append a point to the reference or neighbour store; a
// full store ignores the item. Mode 2 walks every pair with different ids,
// bins the distance, emits BUCKETS result items (bucket_index, bucket_value,
// last on the final one) and clears counts. Mode 3 is dropped.
// Sequence: a pair with equal ids runs store read, difference and advance; any
// other pair runs store read, difference, three squares on one shared
// multiplier, a sum, one bucket edge per cycle and an advance. Per bucket, an
// empty one runs its setup and then the output step. A filled one runs a setup
// multiply, a multiply for w*w and slice multiplies on the shared 32x32 multiplier
// for the denominator, a 128-step restoring divider and an output step. A final
// step clears the counts. Stall on the input channel is high whenever the
// sequencer is busy. If the receiver stalls the output, the item holds in the
// output register and the sequencer waits before the next item. Reset clears
// counts, config to defaults and the sequencer; stores need no clear.
// Config writes are taken in any cycle; write them only while idle.
`default_nettype none
`include "assert_macros.svh"
module pair_distance_histogram #(
    parameter int MAX_POINTS  = pdh_pkg::MAX_POINTS_DEF,
    parameter int BUCKETS     = pdh_pkg::BUCKETS_DEF,
    parameter int COORD_WIDTH = pdh_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    mode,
    input  wire logic signed [COORD_WIDTH-1:0] pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] pos_z,
    input  wire logic [15:0]                   object_id,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [31:0]                   cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [3:0]                         bucket_index,
    output logic [31:0]                        bucket_value,
    output logic                               last
);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int BW  = $clog2(BUCKETS);
    localparam int BCW = $clog2(BUCKETS + 1);
    localparam int CW  = pdh_pkg::CNT_W;
    localparam int PTW = 3 * COORD_WIDTH + 16;

    // point stores, one entry per point: x, y, z, id
    logic [PTW-1:0] ref_mem [MAX_POINTS];
    logic [PTW-1:0] nbr_mem [MAX_POINTS];
    logic [PTW-1:0] ref_rd_reg, nbr_rd_reg;

    logic [23:0] width_reg;
    logic [31:0] area_reg;
    logic [PCW-1:0] ref_cnt_reg, ref_cnt_next, nbr_cnt_reg, nbr_cnt_next;
    logic [CW-1:0] bcnt_reg [BUCKETS];
    logic [CW-1:0] total_reg, total_next;

    pdh_pkg::state_t state_reg, state_next;
    logic [PW-1:0] ri_reg, ri_next, ni_reg, ni_next;
    logic [BCW-1:0] k_reg, k_next;       // bucket edge multiple / bucket number
    logic [1:0] ax_reg, ax_next;         // axis being squared
    logic [3:0] step_reg, step_next;     // multiply step within a bucket
    logic [31:0] dx_reg, dy_reg, dz_reg;
    logic [2:0] dok_reg;
    logic [31:0] edge_reg, edge_next;    // current bucket edge, k*w
    logic [63:0] acc_reg, acc_next;      // distance squared / numerator part
    logic [63:0] sq_reg, sq_next;
    logic [127:0] den_reg, den_next;
    logic [127:0] prod_reg, prod_next;   // running product of den and a factor
    logic [127:0] num_reg, num_next;
    logic [127:0] rem_reg, rem_next;
    logic [6:0] bit_reg, bit_next;
    logic [31:0] q_reg, q_next;
    logic sat_reg, sat_next;
    logic drop_reg, drop_next;

    logic ov_reg, ov_next;
    logic [3:0] oi_reg, oi_next;
    logic [31:0] oval_reg, oval_next;
    logic olast_reg, olast_next;

    // shared multiplier operands
    logic [31:0] ma, mb;
    logic [63:0] mp;
    assign mp = ma * mb;

    logic in_acc;
    assign in_stall  = (state_reg != pdh_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign bucket_index = oi_reg;
    assign bucket_value = oval_reg;
    assign last = olast_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= pdh_pkg::WIDTH_RESET;
            area_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pdh_pkg::CFG_WIDTH)
                width_reg <= cfg_data[23:0];
            else
                area_reg <= cfg_data;
        end
    end

    // stores: write on load, read at the pair walk indexes
    always_ff @(posedge clk)
    begin
        if (in_acc && mode == pdh_pkg::MODE_REF && ref_cnt_reg < PCW'(MAX_POINTS))
            ref_mem[ref_cnt_reg[PW-1:0]] <= {pos_x, pos_y, pos_z, object_id};
        if (in_acc && mode == pdh_pkg::MODE_NBR && nbr_cnt_reg < PCW'(MAX_POINTS))
            nbr_mem[nbr_cnt_reg[PW-1:0]] <= {pos_x, pos_y, pos_z, object_id};
        ref_rd_reg <= ref_mem[ri_reg];
        nbr_rd_reg <= nbr_mem[ni_reg];
    end

    // axis differences, sign extended to 34 bits
    function automatic logic [33:0] ext(input logic [COORD_WIDTH-1:0] v);
        ext = 34'($signed(v));
    endfunction

    logic [33:0] ddx, ddy, ddz;
    logic [33:0] adx, ady, adz;
    assign ddx = ext(ref_rd_reg[PTW-1 -: COORD_WIDTH]) - ext(nbr_rd_reg[PTW-1 -: COORD_WIDTH]);
    assign ddy = ext(ref_rd_reg[PTW-1-COORD_WIDTH -: COORD_WIDTH])
               - ext(nbr_rd_reg[PTW-1-COORD_WIDTH -: COORD_WIDTH]);
    assign ddz = ext(ref_rd_reg[16 +: COORD_WIDTH]) - ext(nbr_rd_reg[16 +: COORD_WIDTH]);
    assign adx = ddx[33] ? -ddx : ddx;
    assign ady = ddy[33] ? -ddy : ddy;
    assign adz = ddz[33] ? -ddz : ddz;

    logic [BCW-1:0] k_m1;
    assign k_m1 = k_reg - BCW'(1);

    logic [128:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, num_reg[127]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // denominator steps: after w*w, four slice steps per factor, high slice first
    logic [3:0] step_m1;
    logic [1:0] slc;
    logic [31:0] fac;
    assign step_m1 = step_reg - 4'd1;
    assign slc = ~step_m1[1:0];
    assign fac = (step_m1[3:2] == 2'd0) ? pdh_pkg::PI_Q30
               : (step_m1[3:2] == 2'd1) ? 32'({k_reg, 1'b1})
               : 32'(total_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == pdh_pkg::ST_DIFF)
        begin
            dx_reg <= adx[31:0];
            dy_reg <= ady[31:0];
            dz_reg <= adz[31:0];
            dok_reg <= {adx[33:31] == 3'b000, ady[33:31] == 3'b000, adz[33:31] == 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdh_pkg::ST_IDLE;
            ref_cnt_reg <= '0;
            nbr_cnt_reg <= '0;
            total_reg <= '0;
            ov_reg <= 1'b0;
            ri_reg <= '0;
            ni_reg <= '0;
            k_reg <= '0;
            ax_reg <= '0;
            step_reg <= '0;
            bit_reg <= '0;
            sat_reg <= 1'b0;
            drop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ref_cnt_reg <= ref_cnt_next;
            nbr_cnt_reg <= nbr_cnt_next;
            total_reg <= total_next;
            ov_reg <= ov_next;
            ri_reg <= ri_next;
            ni_reg <= ni_next;
            k_reg <= k_next;
            ax_reg <= ax_next;
            step_reg <= step_next;
            bit_reg <= bit_next;
            sat_reg <= sat_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
        acc_reg <= acc_next;
        sq_reg <= sq_next;
        den_reg <= den_next;
        prod_reg <= prod_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        oi_reg <= oi_next;
        oval_reg <= oval_next;
        olast_reg <= olast_next;
    end

    // bucket counters
    logic inc_bucket, clr_counts;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
                bcnt_reg[i] <= '0;
        end
        else if (clr_counts)
        begin
            for (int i = 0; i < BUCKETS; i++)
                bcnt_reg[i] <= '0;
        end
        else if (inc_bucket && bcnt_reg[k_m1[BW-1:0]] != pdh_pkg::COUNT_MAX)
            bcnt_reg[k_m1[BW-1:0]] <= bcnt_reg[k_m1[BW-1:0]] + CW'(1);
    end

    logic [CW-1:0] cur_cnt;
    assign cur_cnt = bcnt_reg[k_reg[BW-1:0]];

    always_comb
    begin
        state_next = state_reg;
        ref_cnt_next = ref_cnt_reg;
        nbr_cnt_next = nbr_cnt_reg;
        total_next = total_reg;
        ri_next = ri_reg;
        ni_next = ni_reg;
        k_next = k_reg;
        ax_next = ax_reg;
        step_next = step_reg;
        bit_next = bit_reg;
        sat_next = sat_reg;
        drop_next = drop_reg;
        edge_next = edge_reg;
        acc_next = acc_reg;
        sq_next = sq_reg;
        den_next = den_reg;
        prod_next = prod_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        ov_next = ov_reg && out_stall;
        oi_next = oi_reg;
        oval_next = oval_reg;
        olast_next = olast_reg;
        inc_bucket = 1'b0;
        clr_counts = 1'b0;
        ma = edge_reg;
        mb = edge_reg;
        unique case (state_reg)
            pdh_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode == pdh_pkg::MODE_REF && ref_cnt_reg < PCW'(MAX_POINTS))
                        ref_cnt_next = ref_cnt_reg + PCW'(1);
                    else if (mode == pdh_pkg::MODE_NBR && nbr_cnt_reg < PCW'(MAX_POINTS))
                        nbr_cnt_next = nbr_cnt_reg + PCW'(1);
                    else if (mode == pdh_pkg::MODE_RUN)
                    begin
                        ri_next = '0;
                        ni_next = '0;
                        if (ref_cnt_reg == '0 || nbr_cnt_reg == '0)
                        begin
                            k_next = '0;
                            state_next = pdh_pkg::ST_NSETUP;
                        end
                        else
                            state_next = pdh_pkg::ST_RD;
                    end
                end
            end
            pdh_pkg::ST_RD:
                state_next = pdh_pkg::ST_DIFF;
            pdh_pkg::ST_DIFF:
            begin
                ax_next = '0;
                acc_next = '0;
                if (ref_rd_reg[15:0] == nbr_rd_reg[15:0])
                    state_next = pdh_pkg::ST_ADV;
                else
                    state_next = pdh_pkg::ST_SQ;
            end
            pdh_pkg::ST_SQ:
            begin
                // square one axis per cycle on the shared multiplier
                unique case (ax_reg)
                    2'd0: begin ma = dx_reg; mb = dx_reg; end
                    2'd1: begin ma = dy_reg; mb = dy_reg; end
                    default: begin ma = dz_reg; mb = dz_reg; end
                endcase
                sq_next = mp;
                if (ax_reg != 2'd0)
                    acc_next = acc_reg + sq_reg;
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                    state_next = pdh_pkg::ST_SUM;
            end
            pdh_pkg::ST_SUM:
            begin
                acc_next = acc_reg + sq_reg;
                k_next = BCW'(1);
                edge_next = 32'(width_reg);
                drop_next = (dok_reg != 3'b111) || (width_reg == '0);
                state_next = pdh_pkg::ST_BIN;
            end
            pdh_pkg::ST_BIN:
            begin
                // find first edge k with (k*w)^2 > d2; bucket is k-1
                if (drop_reg)
                    state_next = pdh_pkg::ST_ADV;
                else if (mp > acc_reg)
                begin
                    inc_bucket = 1'b1;
                    if (total_reg != pdh_pkg::COUNT_MAX)
                        total_next = total_reg + CW'(1);
                    state_next = pdh_pkg::ST_ADV;
                end
                else if (k_reg == BCW'(BUCKETS))
                    state_next = pdh_pkg::ST_ADV;
                else
                begin
                    k_next = k_reg + BCW'(1);
                    edge_next = edge_reg + 32'(width_reg);
                end
            end
            pdh_pkg::ST_ADV:
            begin
                if (PCW'(ni_reg) + PCW'(1) < nbr_cnt_reg)
                begin
                    ni_next = ni_reg + PW'(1);
                    state_next = pdh_pkg::ST_RD;
                end
                else if (PCW'(ri_reg) + PCW'(1) < ref_cnt_reg)
                begin
                    ni_next = '0;
                    ri_next = ri_reg + PW'(1);
                    state_next = pdh_pkg::ST_RD;
                end
                else
                begin
                    k_next = '0;
                    state_next = pdh_pkg::ST_NSETUP;
                end
            end
            pdh_pkg::ST_NSETUP:
            begin
                ma = 32'(cur_cnt);
                mb = area_reg;
                acc_next = mp;
                step_next = '0;
                state_next = pdh_pkg::ST_DMUL;
                if (total_reg == '0 || cur_cnt == '0)
                begin
                    q_next = '0;
                    state_next = pdh_pkg::ST_OUT;
                end
            end
            pdh_pkg::ST_DMUL:
            begin
                // den = w*w, then times PI, 2k+1 and total; each factor takes
                // four steps, one 32-bit slice of den per step, high slice first
                num_next = {acc_reg, 64'd0} >> 10;
                if (step_reg == 4'd0)
                begin
                    ma = {8'd0, width_reg};
                    mb = {8'd0, width_reg};
                    den_next = {64'd0, mp};
                end
                else
                begin
                    ma = den_reg[{slc, 5'd0} +: 32];
                    mb = fac;
                    prod_next = ((step_m1[1:0] == 2'd0) ? 128'd0 : {prod_reg[95:0], 32'd0})
                              + {64'd0, mp};
                    if (step_m1[1:0] == 2'd3)
                        den_next = prod_next;
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd12)
                begin
                    rem_next = '0;
                    q_next = '0;
                    sat_next = 1'b0;
                    bit_next = 7'd127;
                    state_next = pdh_pkg::ST_DIV;
                end
            end
            pdh_pkg::ST_DIV:
            begin
                // one restoring divide step per cycle, high bit first
                num_next = {num_reg[126:0], 1'b0};
                if (!rem_sub[128])
                begin
                    rem_next = rem_sub[127:0];
                    if (bit_reg >= 7'd32)
                        sat_next = 1'b1;
                    else
                        q_next = q_reg | (32'd1 << bit_reg[4:0]);
                end
                else
                    rem_next = rem_sh[127:0];
                bit_next = bit_reg - 7'd1;
                if (bit_reg == 7'd0)
                    state_next = pdh_pkg::ST_OUT;
            end
            pdh_pkg::ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    oi_next = 4'(k_reg);
                    oval_next = sat_reg ? 32'hFFFF_FFFF : q_reg;
                    olast_next = (k_reg == BCW'(BUCKETS - 1));
                    sat_next = 1'b0;
                    if (k_reg == BCW'(BUCKETS - 1))
                        state_next = pdh_pkg::ST_CLR;
                    else
                    begin
                        k_next = k_reg + BCW'(1);
                        state_next = pdh_pkg::ST_NSETUP;
                    end
                end
            end
            pdh_pkg::ST_CLR:
            begin
                clr_counts = 1'b1;
                total_next = '0;
                ref_cnt_next = '0;
                nbr_cnt_next = '0;
                state_next = pdh_pkg::ST_IDLE;
            end
            default: state_next = pdh_pkg::ST_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != pdh_pkg::ST_IDLE, in_stall)
    `ASSERT_NEXT(a_clr_idle, clk, rst_n, state_reg == pdh_pkg::ST_CLR,
        state_reg == pdh_pkg::ST_IDLE && total_reg == '0)
    `ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid && last, bucket_index == 4'(BUCKETS - 1))
endmodule
`default_nettype wire
